/* sv/tfg_pkg.sv */
// Package for the UDP test frame generator: payload structs, queue entry,
// configuration register set and register index codes.
// No dependencies.
package tfg_pkg;

    // Held payload length and frame byte position widths
    localparam int LEN_W      = 11;
    localparam int POS_W      = 11;
    // Raw (unfolded) IPv4 header sum: nine 16-bit terms
    localparam int SUM_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int QUEUE_DEPTH = 2;

    // Ethernet + IPv4 + UDP header bytes
    localparam logic [POS_W-1:0] HDR_BYTES = 11'd42;
    localparam logic [15:0] IP_HDR_UDP_BYTES = 16'd28;
    localparam logic [15:0] UDP_HDR_BYTES    = 16'd8;
    localparam logic [15:0] IP_VER_IHL_TOS   = 16'h4500;
    localparam logic [15:0] IP_FLAGS_DF      = 16'h4000;
    localparam logic [7:0]  IP_PROTO_UDP     = 8'd17;

    localparam logic [47:0] DEST_MAC_RST = 48'hFFFF_FFFF_FFFF;
    localparam logic [7:0]  TTL_RST      = 8'd64;
    localparam logic [15:0] IDENT_RST    = 16'hCAA8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_MAC    = 3'd0,
        CFG_SOURCE_MAC  = 3'd1,
        CFG_DEST_IP     = 3'd2,
        CFG_SOURCE_IP   = 3'd3,
        CFG_SOURCE_PORT = 3'd4,
        CFG_DEST_PORT   = 3'd5,
        CFG_TTL         = 3'd6,
        CFG_IDENT       = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic        opcode;
        logic [15:0] payload_length;
    } in_item_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       first_flag;
        logic       last_flag;
    } out_item_t;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] dest_ip;
        logic [31:0] source_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  time_to_live;
        logic [15:0] ident_word;
    } cfg_t;

    // One classified item on its way from front to back
    typedef struct packed {
        logic             active;
        logic             first;
        logic             last;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic [SUM_W-1:0] hdr_sum;
    } q_entry_t;

endpackage

/* sv/tfg_cfg.sv */
// Configuration register file of the UDP test frame generator.
// Depends on tfg_pkg.
module tfg_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tfg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tfg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output tfg_pkg::cfg_t                   cfg
);

    tfg_pkg::cfg_t cfg_reg;
    tfg_pkg::cfg_t cfg_next;

    // Decode the register index and update one field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (tfg_pkg::cfg_index_t'(cfg_index))
                tfg_pkg::CFG_DEST_MAC:    cfg_next.dest_mac     = cfg_wdata;
                tfg_pkg::CFG_SOURCE_MAC:  cfg_next.source_mac   = cfg_wdata;
                tfg_pkg::CFG_DEST_IP:     cfg_next.dest_ip      = cfg_wdata[31:0];
                tfg_pkg::CFG_SOURCE_IP:   cfg_next.source_ip    = cfg_wdata[31:0];
                tfg_pkg::CFG_SOURCE_PORT: cfg_next.source_port  = cfg_wdata[15:0];
                tfg_pkg::CFG_DEST_PORT:   cfg_next.dest_port    = cfg_wdata[15:0];
                tfg_pkg::CFG_TTL:         cfg_next.time_to_live = cfg_wdata[7:0];
                tfg_pkg::CFG_IDENT:       cfg_next.ident_word   = cfg_wdata[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_mac     <= tfg_pkg::DEST_MAC_RST;
            cfg_reg.source_mac   <= '0;
            cfg_reg.dest_ip      <= '0;
            cfg_reg.source_ip    <= '0;
            cfg_reg.source_port  <= '0;
            cfg_reg.dest_port    <= '0;
            cfg_reg.time_to_live <= tfg_pkg::TTL_RST;
            cfg_reg.ident_word   <= tfg_pkg::IDENT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/tfg_front.sv */
// Front end of the UDP test frame generator: accepts items, tracks the frame
// position and classifies each item into a queue entry. Depends on tfg_pkg.
module tfg_front
#(
    parameter int MAX_PAYLOAD = 1472
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  tfg_pkg::in_item_t   item,
    input  tfg_pkg::cfg_t       cfg,
    output tfg_pkg::q_entry_t   entry
);

    localparam logic [tfg_pkg::LEN_W-1:0] MaxLen = tfg_pkg::LEN_W'(MAX_PAYLOAD);

    logic [tfg_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [tfg_pkg::LEN_W-1:0] len_reg, len_next;
    logic                      active_reg, active_next;

    logic [tfg_pkg::LEN_W-1:0] clamp_len;
    logic [tfg_pkg::POS_W-1:0] total_cur, total_next;
    logic [tfg_pkg::POS_W:0]   pos_inc, pos_next_inc;
    logic [15:0]               ip_total;

    // Clamp the requested payload length
    assign clamp_len = (item.payload_length > 16'(MAX_PAYLOAD)) ? MaxLen
                                                                 : item.payload_length[tfg_pkg::LEN_W-1:0];

    assign total_cur = tfg_pkg::HDR_BYTES + len_reg;
    assign pos_inc   = {1'b0, pos_reg} + 1'b1;

    // Start a frame, advance within it, or drop to idle after its last byte
    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        active_next = active_reg;
        if (accept)
        begin
            if (item.opcode)
            begin
                len_next    = clamp_len;
                pos_next    = '0;
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                if (pos_inc < {1'b0, total_cur})
                begin
                    pos_next = pos_inc[tfg_pkg::POS_W-1:0];
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            active_reg <= active_next;
        end
    end

    // Classify the item from the position it leaves behind
    assign total_next   = tfg_pkg::HDR_BYTES + len_next;
    assign pos_next_inc = {1'b0, pos_next} + 1'b1;

    // Raw IPv4 header sum; folded by the back end on the first byte
    assign ip_total = tfg_pkg::IP_HDR_UDP_BYTES + 16'(len_next);

    always_comb
    begin
        entry.active  = active_next;
        entry.first   = active_next && (pos_next == '0);
        entry.last    = active_next && (pos_next_inc == {1'b0, total_next});
        entry.pos     = pos_next;
        entry.len     = len_next;
        entry.hdr_sum = tfg_pkg::SUM_W'(tfg_pkg::IP_VER_IHL_TOS)
                      + tfg_pkg::SUM_W'(ip_total)
                      + tfg_pkg::SUM_W'(cfg.ident_word)
                      + tfg_pkg::SUM_W'(tfg_pkg::IP_FLAGS_DF)
                      + tfg_pkg::SUM_W'({cfg.time_to_live, tfg_pkg::IP_PROTO_UDP})
                      + tfg_pkg::SUM_W'(cfg.source_ip[31:16])
                      + tfg_pkg::SUM_W'(cfg.source_ip[15:0])
                      + tfg_pkg::SUM_W'(cfg.dest_ip[31:16])
                      + tfg_pkg::SUM_W'(cfg.dest_ip[15:0]);
    end

    // An active frame never points past its own last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ({1'b0, pos_reg} < {1'b0, total_cur}))
        else $error("front position beyond frame end");

endmodule

/* sv/tfg_queue.sv */
// Short queue between front and back end of the UDP test frame generator.
// Depends on tfg_pkg.
module tfg_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  tfg_pkg::q_entry_t   wr_entry,
    output logic                full,
    input  logic                rd_en,
    output logic                rd_valid,
    output tfg_pkg::q_entry_t   rd_entry
);

    localparam int PtrW = $clog2(tfg_pkg::QUEUE_DEPTH);

    tfg_pkg::q_entry_t     mem [tfg_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]         count_reg, count_next;

    assign full     = (count_reg == (PtrW+1)'(tfg_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = mem[rd_ptr_reg];

    // Advance pointers and occupancy on each transfer
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PtrW+1)'(tfg_pkg::QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue lost a write");

endmodule

/* sv/tfg_back.sv */
// Back end of the UDP test frame generator: turns a queue entry into a frame
// byte from live configuration and the latched checksum. Depends on tfg_pkg.
module tfg_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  tfg_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  tfg_pkg::q_entry_t   q_entry,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output tfg_pkg::out_item_t  result
);

    logic                 out_full_reg, out_full_next;
    tfg_pkg::out_item_t   out_reg;
    logic [15:0]          csum_reg, csum_next;

    logic                 load;
    logic [16:0]          fold1;
    logic [15:0]          fold2;
    logic [15:0]          ip_len, udp_len;
    logic [7:0]           frame_byte;
    logic [2:0]           dmac_sel, smac_sel;
    logic [3:0]           smac_off;
    logic [1:0]           sip_sel, dip_sel;
    logic [4:0]           sip_off;
    logic [5:0]           dip_off;
    logic [tfg_pkg::POS_W-1:0] p;

    // Take the queue head whenever the output register is free or leaving
    assign load  = q_valid && (!out_full_reg || pop);
    assign q_rd  = load;
    assign empty = !out_full_reg;

    // Fold the raw header sum to 16 bits and complement it
    assign fold1 = {1'b0, q_entry.hdr_sum[15:0]} + 17'(q_entry.hdr_sum[19:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    always_comb
    begin
        csum_next = csum_reg;
        if (load && q_entry.first)
        begin
            csum_next = ~fold2;
        end
    end

    // Byte selects within the multi-byte fields
    assign p        = q_entry.pos;
    assign ip_len   = tfg_pkg::IP_HDR_UDP_BYTES + 16'(q_entry.len);
    assign udp_len  = tfg_pkg::UDP_HDR_BYTES + 16'(q_entry.len);
    assign dmac_sel = 3'd5 - p[2:0];
    assign smac_off = 4'd11 - p[3:0];
    assign smac_sel = smac_off[2:0];
    assign sip_off  = 5'd29 - p[4:0];
    assign sip_sel  = sip_off[1:0];
    assign dip_off  = 6'd33 - p[5:0];
    assign dip_sel  = dip_off[1:0];

    // Pick the frame byte for this position
    always_comb
    begin
        frame_byte = 8'h00;
        if (p < 11'd6)
        begin
            frame_byte = cfg.dest_mac[{dmac_sel, 3'b000} +: 8];
        end
        else if (p < 11'd12)
        begin
            frame_byte = cfg.source_mac[{smac_sel, 3'b000} +: 8];
        end
        else if (p >= 11'd26 && p < 11'd30)
        begin
            frame_byte = cfg.source_ip[{sip_sel, 3'b000} +: 8];
        end
        else if (p >= 11'd30 && p < 11'd34)
        begin
            frame_byte = cfg.dest_ip[{dip_sel, 3'b000} +: 8];
        end
        else if (p >= tfg_pkg::HDR_BYTES)
        begin
            frame_byte = p[7:0] - tfg_pkg::HDR_BYTES[7:0];
        end
        else
        begin
            case (p)
                11'd12:  frame_byte = 8'h08;
                11'd14:  frame_byte = tfg_pkg::IP_VER_IHL_TOS[15:8];
                11'd16:  frame_byte = ip_len[15:8];
                11'd17:  frame_byte = ip_len[7:0];
                11'd18:  frame_byte = cfg.ident_word[15:8];
                11'd19:  frame_byte = cfg.ident_word[7:0];
                11'd20:  frame_byte = tfg_pkg::IP_FLAGS_DF[15:8];
                11'd22:  frame_byte = cfg.time_to_live;
                11'd23:  frame_byte = tfg_pkg::IP_PROTO_UDP;
                11'd24:  frame_byte = csum_reg[15:8];
                11'd25:  frame_byte = csum_reg[7:0];
                11'd34:  frame_byte = cfg.source_port[15:8];
                11'd35:  frame_byte = cfg.source_port[7:0];
                11'd36:  frame_byte = cfg.dest_port[15:8];
                11'd37:  frame_byte = cfg.dest_port[7:0];
                11'd38:  frame_byte = udp_len[15:8];
                11'd39:  frame_byte = udp_len[7:0];
                default: frame_byte = 8'h00;
            endcase
        end
    end

    // Hold the result until it is taken
    always_comb
    begin
        out_full_next = out_full_reg;
        if (load)
        begin
            out_full_next = 1'b1;
        end
        else if (pop)
        begin
            out_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
            csum_reg     <= '0;
        end
        else
        begin
            out_full_reg <= out_full_next;
            csum_reg     <= csum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.byte_valid <= q_entry.active;
            out_reg.out_byte   <= q_entry.active ? frame_byte : 8'h00;
            out_reg.first_flag <= q_entry.first;
            out_reg.last_flag  <= q_entry.last;
        end
    end

    assign result = out_reg;

    // An idle result carries no frame markers
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_full_reg && !out_reg.byte_valid) |-> (!out_reg.first_flag && !out_reg.last_flag))
        else $error("flags set on an idle result");

    // A waiting result is never overwritten before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_full_reg && !pop) |-> !load)
        else $error("result overwritten while held");

endmodule

/* sv/udp_test_frame_generator_core.sv */
// A result goes from its accepted item through a queue slot, then the output
// register; one item per cycle while pop keeps the output and queue from filling.
// With pop held low, the output register and the two-entry queue take three
// transfers before full rises; each pop then frees one slot for the next cycle.
// Reset (rst_n, asynchronous, active low) empties queue and output, makes
// the frame idle and loads the default configuration registers.
// Top level of the UDP test frame generator; depends on tfg_pkg and submodules.
module udp_test_frame_generator_core
#(
    parameter int MAX_PAYLOAD = 1472
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  tfg_pkg::in_item_t               item,
    output logic                            empty,
    input  logic                            pop,
    output tfg_pkg::out_item_t              result,
    input  logic                            cfg_wr_en,
    input  logic [tfg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tfg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    tfg_pkg::cfg_t      cfg;
    tfg_pkg::q_entry_t  wr_entry;
    tfg_pkg::q_entry_t  rd_entry;
    logic               q_full;
    logic               q_valid;
    logic               q_rd;
    logic               accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    tfg_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tfg_front
    #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    )
    u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .entry  (wr_entry)
    );

    tfg_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_entry (wr_entry),
        .full     (q_full),
        .rd_en    (q_rd),
        .rd_valid (q_valid),
        .rd_entry (rd_entry)
    );

    tfg_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_entry (rd_entry),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

/* verif/tb_udp_test_frame_generator_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for udp_test_frame_generator_core: drives start and advance
// items, predicts every frame byte and compares each result transfer.
// Depends on tfg_pkg and the generator RTL.
module tb_udp_test_frame_generator_core;

    localparam int unsigned FRAME_MAX_PAYLOAD = 1472;
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_START   = 1'b1;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    tfg_pkg::in_item_t      item;
    logic                   empty;
    logic                   pop = 1'b0;
    tfg_pkg::out_item_t     result;
    logic                   cfg_wr_en;
    tfg_pkg::cfg_index_t    cfg_index;
    logic [47:0]            cfg_wdata;

    // Stimulus shaping: 0 means no idling on that side
    int unsigned     gap_mode;
    int unsigned     stall_mode;
    int unsigned     pop_hold;
    int unsigned     mismatch_count;

    // Predicted generator state and register copy
    tfg_pkg::cfg_t   model_cfg;
    int unsigned     model_pos;
    int unsigned     model_len;
    logic [15:0]     model_csum;
    logic            model_active;

    tfg_pkg::out_item_t expected_bytes[$];

    udp_test_frame_generator_core #(
        .MAX_PAYLOAD (FRAME_MAX_PAYLOAD)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Ones-complement sum over the IPv4 header, folded and inverted
    function automatic logic [15:0] ipv4_header_checksum(int unsigned len);
        logic [31:0] acc;
        acc = 32'(tfg_pkg::IP_VER_IHL_TOS)
            + ((32'(tfg_pkg::IP_HDR_UDP_BYTES) + len) & 32'hFFFF)
            + 32'(model_cfg.ident_word) + 32'(tfg_pkg::IP_FLAGS_DF)
            + 32'({model_cfg.time_to_live, tfg_pkg::IP_PROTO_UDP})
            + 32'(model_cfg.source_ip[31:16]) + 32'(model_cfg.source_ip[15:0])
            + 32'(model_cfg.dest_ip[31:16]) + 32'(model_cfg.dest_ip[15:0]);
        while (acc[31:16] != 16'd0)
            acc = 32'(acc[31:16]) + 32'(acc[15:0]);
        return ~acc[15:0];
    endfunction

    // Byte at position p of the frame, header fields read from the live registers
    function automatic logic [7:0] frame_byte_at(int unsigned p);
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        ip_len  = 16'(32'(tfg_pkg::IP_HDR_UDP_BYTES) + model_len);
        udp_len = 16'(32'(tfg_pkg::UDP_HDR_BYTES) + model_len);
        if (p < 6)
            return model_cfg.dest_mac[8*(5-p) +: 8];
        if (p < 12)
            return model_cfg.source_mac[8*(11-p) +: 8];
        if (p >= 26 && p < 30)
            return model_cfg.source_ip[8*(29-p) +: 8];
        if (p >= 30 && p < 34)
            return model_cfg.dest_ip[8*(33-p) +: 8];
        if (p >= 32'(tfg_pkg::HDR_BYTES))
            return 8'(p - 32'(tfg_pkg::HDR_BYTES));
        case (p)
            12: return ETHERTYPE_IPV4[15:8];
            14: return tfg_pkg::IP_VER_IHL_TOS[15:8];
            16: return ip_len[15:8];
            17: return ip_len[7:0];
            18: return model_cfg.ident_word[15:8];
            19: return model_cfg.ident_word[7:0];
            20: return tfg_pkg::IP_FLAGS_DF[15:8];
            22: return model_cfg.time_to_live;
            23: return tfg_pkg::IP_PROTO_UDP;
            24: return model_csum[15:8];
            25: return model_csum[7:0];
            34: return model_cfg.source_port[15:8];
            35: return model_cfg.source_port[7:0];
            36: return model_cfg.dest_port[15:8];
            37: return model_cfg.dest_port[7:0];
            38: return udp_len[15:8];
            39: return udp_len[7:0];
            default: return 8'h00;
        endcase
    endfunction

    // Advance the predicted frame by one item and return the byte it yields
    function automatic tfg_pkg::out_item_t next_frame_output(tfg_pkg::in_item_t it);
        tfg_pkg::out_item_t r;
        int unsigned        frame_len;
        if (it.opcode == OP_START)
        begin
            model_len = (it.payload_length > FRAME_MAX_PAYLOAD) ? FRAME_MAX_PAYLOAD
                                                                : it.payload_length;
            model_csum   = ipv4_header_checksum(model_len);
            model_pos    = 0;
            model_active = 1'b1;
        end
        else if (model_active)
        begin
            if (model_pos + 1 < 32'(tfg_pkg::HDR_BYTES) + model_len)
                model_pos++;
            else
                model_active = 1'b0;
        end
        r = '0;
        if (model_active)
        begin
            frame_len    = 32'(tfg_pkg::HDR_BYTES) + model_len;
            r.byte_valid = 1'b1;
            r.out_byte   = frame_byte_at(model_pos);
            r.first_flag = (model_pos == 0);
            r.last_flag  = (model_pos + 1 == frame_len);
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [7:0] want, logic [7:0] got);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        mismatch_count++;
    endtask

    // Follow register writes, accepted items and result transfers at each edge
    always @(posedge clk)
    begin : frame_monitor
        tfg_pkg::out_item_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    tfg_pkg::CFG_DEST_MAC:    model_cfg.dest_mac     = cfg_wdata;
                    tfg_pkg::CFG_SOURCE_MAC:  model_cfg.source_mac   = cfg_wdata;
                    tfg_pkg::CFG_DEST_IP:     model_cfg.dest_ip      = cfg_wdata[31:0];
                    tfg_pkg::CFG_SOURCE_IP:   model_cfg.source_ip    = cfg_wdata[31:0];
                    tfg_pkg::CFG_SOURCE_PORT: model_cfg.source_port  = cfg_wdata[15:0];
                    tfg_pkg::CFG_DEST_PORT:   model_cfg.dest_port    = cfg_wdata[15:0];
                    tfg_pkg::CFG_TTL:         model_cfg.time_to_live = cfg_wdata[7:0];
                    tfg_pkg::CFG_IDENT:       model_cfg.ident_word   = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (push && !full)
                expected_bytes.push_back(next_frame_output(item));
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual %p",
                             $time, result);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (result.byte_valid !== want.byte_valid)
                        report_mismatch("byte_valid", want.byte_valid, result.byte_valid);
                    if (result.out_byte !== want.out_byte)
                        report_mismatch("out_byte", want.out_byte, result.out_byte);
                    if (result.first_flag !== want.first_flag)
                        report_mismatch("first_flag", want.first_flag, result.first_flag);
                    if (result.last_flag !== want.last_flag)
                        report_mismatch("last_flag", want.last_flag, result.last_flag);
                end
            end
        end
    end

    // Gap length for the sender or the result side: mostly none or short, a few long
    function automatic int unsigned pick_gap(int unsigned mode);
        int unsigned r;
        if (mode == 0)
            return 0;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Drive pop, stalling the result side at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_hold = 0;
        end
        else if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else
        begin
            pop <= 1'b1;
            pop_hold = pick_gap(stall_mode);
        end
    end

    // Offer one item and hold it until the transfer happens
    task automatic send_item(logic op, logic [15:0] len);
        int unsigned gap;
        gap = pick_gap(gap_mode);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= '{opcode: op, payload_length: len};
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_advance();
        send_item(OP_ADVANCE, 16'($urandom));
    endtask

    // Start a frame and advance through it, plus extra advances past its end
    task automatic run_frame(logic [15:0] len, int unsigned extra);
        int unsigned frame_len;
        frame_len = 32'(tfg_pkg::HDR_BYTES)
                  + ((len > FRAME_MAX_PAYLOAD) ? FRAME_MAX_PAYLOAD : len);
        send_item(OP_START, len);
        repeat (frame_len - 1 + extra) send_advance();
    endtask

    // Hold the sender until every expected byte has been taken, then settle
    task automatic wait_drain();
        push <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(tfg_pkg::cfg_index_t idx, logic [47:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Write the whole register set, back to back, with noise above narrow fields
    task automatic load_regs(tfg_pkg::cfg_t c);
        logic [47:0]         data;
        tfg_pkg::cfg_index_t idx;
        for (int i = 0; i < 8; i++)
        begin
            idx  = tfg_pkg::cfg_index_t'(i);
            data = {16'($urandom), 32'($urandom)};
            case (idx)
                tfg_pkg::CFG_DEST_MAC:    data        = c.dest_mac;
                tfg_pkg::CFG_SOURCE_MAC:  data        = c.source_mac;
                tfg_pkg::CFG_DEST_IP:     data[31:0]  = c.dest_ip;
                tfg_pkg::CFG_SOURCE_IP:   data[31:0]  = c.source_ip;
                tfg_pkg::CFG_SOURCE_PORT: data[15:0]  = c.source_port;
                tfg_pkg::CFG_DEST_PORT:   data[15:0]  = c.dest_port;
                tfg_pkg::CFG_TTL:         data[7:0]   = c.time_to_live;
                tfg_pkg::CFG_IDENT:       data[15:0]  = c.ident_word;
                default: ;
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= data;
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic tfg_pkg::cfg_t random_settings();
        tfg_pkg::cfg_t c;
        int unsigned   r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        c.dest_mac     = {16'($urandom), 32'($urandom)};
        c.source_mac   = {16'($urandom), 32'($urandom)};
        c.dest_ip      = $urandom;
        c.source_ip    = $urandom;
        c.source_port  = 16'($urandom);
        c.dest_port    = 16'($urandom);
        c.time_to_live = 8'($urandom);
        c.ident_word   = 16'($urandom);
        return c;
    endfunction

    // Idle advances, then a zero payload frame walked past its end with reset settings
    task automatic test_reset_defaults();
        gap_mode   = 0;
        stall_mode = 0;
        send_advance();
        send_advance();
        run_frame(16'd0, 2);
        wait_drain();
    endtask

    // All-ones and all-zeros registers, shortest frames
    task automatic test_register_extremes();
        gap_mode   = 1;
        stall_mode = 1;
        load_regs('1);
        run_frame(16'd0, 1);
        wait_drain();
        load_regs('0);
        run_frame(16'd1, 1);
        wait_drain();
    endtask

    // Lengths around and beyond the payload limit; each later start cuts the previous frame
    task automatic test_length_clamp();
        send_item(OP_START, 16'hFFFF);
        repeat (20) send_advance();
        send_item(OP_START, 16'(FRAME_MAX_PAYLOAD + 1));
        repeat (20) send_advance();
        send_item(OP_START, 16'(FRAME_MAX_PAYLOAD));
        repeat (20) send_advance();
        send_item(OP_START, 16'(FRAME_MAX_PAYLOAD - 1));
        repeat (20) send_advance();
        wait_drain();
    endtask

    // Restart in the middle of a frame, then again on its very first byte
    task automatic test_restart();
        send_item(OP_START, 16'd5);
        repeat (10) send_advance();
        send_item(OP_START, 16'd7);
        send_item(OP_START, 16'd2);
        repeat (45) send_advance();
        wait_drain();
    endtask

    // Change registers mid-frame: header bytes follow, the checksum stays latched
    task automatic test_live_registers();
        load_regs(random_settings());
        send_item(OP_START, 16'd4);
        repeat (15) send_advance();
        wait_drain();
        write_reg(tfg_pkg::CFG_TTL, {16'($urandom), 32'($urandom)});
        write_reg(tfg_pkg::CFG_SOURCE_IP, {16'($urandom), 32'($urandom)});
        write_reg(tfg_pkg::CFG_IDENT, {16'($urandom), 32'($urandom)});
        write_reg(tfg_pkg::CFG_DEST_PORT, {16'($urandom), 32'($urandom)});
        repeat (33) send_advance();
        wait_drain();
    endtask

    // A frame of the largest payload, walked through its header into the payload
    task automatic test_max_frame();
        gap_mode   = 0;
        stall_mode = 0;
        load_regs(random_settings());
        send_item(OP_START, 16'(FRAME_MAX_PAYLOAD));
        repeat (60) send_advance();
        wait_drain();
    endtask

    // Mostly complete frames of random length, some cut short, some stray advances
    task automatic test_random_frames();
        int unsigned sent;
        int unsigned frames;
        int unsigned r;
        int unsigned adv;
        int unsigned frame_len;
        logic [15:0] len;
        sent   = 0;
        frames = 0;
        while (sent < 100)
        begin
            if (frames % 4 == 3)
            begin
                wait_drain();
                load_regs(random_settings());
                gap_mode   = $urandom_range(0, 1);
                stall_mode = $urandom_range(0, 1);
            end
            r = $urandom_range(99);
            if (r < 8)
            begin
                adv = $urandom_range(1, 3);
                repeat (adv) send_advance();
                sent += adv;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 60)
                    len = 16'($urandom_range(0, 40));
                else if (r < 80)
                    len = 16'($urandom_range(41, 200));
                else
                    len = 16'($urandom);
                frame_len = 32'(tfg_pkg::HDR_BYTES)
                          + ((len > FRAME_MAX_PAYLOAD) ? FRAME_MAX_PAYLOAD : len);
                if ($urandom_range(99) < 70)
                    adv = frame_len - 1 + $urandom_range(0, 2);
                else
                    adv = $urandom_range(0, frame_len - 1);
                if (adv > 80)
                    adv = 80;
                send_item(OP_START, len);
                repeat (adv) send_advance();
                sent += adv + 1;
            end
            frames++;
        end
        wait_drain();
    endtask

    // Give up on a hung run
    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        item           = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = tfg_pkg::CFG_DEST_MAC;
        cfg_wdata      = '0;
        gap_mode       = 0;
        stall_mode     = 0;
        mismatch_count = 0;
        model_cfg      = '{dest_mac: tfg_pkg::DEST_MAC_RST, source_mac: '0, dest_ip: '0,
                           source_ip: '0, source_port: '0, dest_port: '0,
                           time_to_live: tfg_pkg::TTL_RST,
                           ident_word: tfg_pkg::IDENT_RST};
        model_pos      = 0;
        model_len      = 0;
        model_csum     = '0;
        model_active   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_length_clamp();
        test_restart();
        test_live_registers();
        test_max_frame();
        test_random_frames();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
